// ----- hdl/edtt_pkg.sv -----
// Package for the earliest deadline timer table.
// Holds operation codes, the slot record layout and the word types shared by the sequencer and the top level.
// No dependencies.
package edtt_pkg;

  localparam int EDTT_NUM_TIMERS = 16;

  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_STOP  = 2'd1;
  localparam logic [1:0] FUNC_FIRE  = 2'd2;

  // One timer slot as kept in the slot memory.
  typedef struct packed {
    logic [3:0]  machine;
    logic [7:0]  level;
    logic [15:0] event_code;
    logic [31:0] due;
    logic [31:0] order;
  } entry_t;

  // One accepted request word.
  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  machine;
    logic [7:0]  level;
    logic [15:0] event_code;
    logic [31:0] delay;
  } cmd_t;

  // One result word of a fire request.
  typedef struct packed {
    logic        fired;
    logic [31:0] time_now;
    logic [3:0]  machine;
    logic [7:0]  level;
    logic [15:0] event_code;
    logic [31:0] due;
  } res_t;

endpackage

// ----- hdl/edtt_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing; used for the timer slot memory.
module edtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/edtt_seq.sv -----
// Request sequencer of the timer table: slot valid bits, clock and order counters,
// and the one-slot-per-cycle scan over the slot memory. Uses edtt_pkg and edtt_ram.
module edtt_seq
  import edtt_pkg::*;
#(
  parameter int NUM_TIMERS = EDTT_NUM_TIMERS
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W = $clog2(NUM_TIMERS + 1);
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(NUM_TIMERS);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_START  = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_RESULT = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic                  op_fire_r, op_fire_nxt;
  cmd_t                  cmd_r, cmd_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]      cmp_idx_r, cmp_idx_nxt;
  logic [NUM_TIMERS-1:0] valid_r, valid_nxt;
  logic [31:0]           clock_now_r, clock_now_nxt;
  logic [31:0]           order_next_r, order_next_nxt;
  logic                  best_found_r, best_found_nxt;
  entry_t                best_r, best_nxt;
  logic [IDX_W-1:0]      best_idx_r, best_idx_nxt;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t           rd_ent;
  logic             better;
  logic             later_due;

  edtt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (NUM_TIMERS)
  ) u_slots (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign rd_ent    = entry_t'(ram_rdata);
  assign cmd_ready = (state_r == S_IDLE);
  assign later_due = best_found_r && (best_r.due > clock_now_r);

  // Strict ordering by due time, then by arrival order; the first valid slot is always taken as the initial best.
  assign better = !best_found_r || (rd_ent.due < best_r.due) ||
                  ((rd_ent.due == best_r.due) && (rd_ent.order < best_r.order));

  assign ram_waddr = cnt_r[IDX_W-1:0];
  assign ram_raddr = cnt_r[IDX_W-1:0];
  assign ram_wdata = '{machine: cmd_r.machine, level: cmd_r.level,
                       event_code: cmd_r.event_code,
                       due: clock_now_r + cmd_r.delay, order: order_next_r};

  always_comb begin
    state_nxt      = state_r;
    op_fire_nxt    = op_fire_r;
    cmd_nxt        = cmd_r;
    cnt_nxt        = cnt_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    valid_nxt      = valid_r;
    clock_now_nxt  = clock_now_r;
    order_next_nxt = order_next_r;
    best_found_nxt = best_found_r;
    best_nxt       = best_r;
    best_idx_nxt   = best_idx_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    res_valid      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_nxt        = cmd;
          cnt_nxt        = '0;
          best_found_nxt = 1'b0;
          case (cmd.func)
            FUNC_START: state_nxt = S_START;
            FUNC_STOP: begin
              state_nxt   = S_SCAN;
              op_fire_nxt = 1'b0;
            end
            FUNC_FIRE: begin
              state_nxt   = S_SCAN;
              op_fire_nxt = 1'b1;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      S_START: begin
        // Walk the valid bits until the first free slot; a full table drops the word.
        if (cnt_r == CNT_END) begin
          state_nxt = S_IDLE;
        end else if (!valid_r[cnt_r[IDX_W-1:0]]) begin
          ram_we                       = 1'b1;
          valid_nxt[cnt_r[IDX_W-1:0]]  = 1'b1;
          order_next_nxt               = order_next_r + 32'd1;
          state_nxt                    = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end

      S_SCAN: begin
        if (cnt_r != CNT_END) begin
          ram_re      = 1'b1;
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = cnt_r[IDX_W-1:0];
          cnt_nxt     = cnt_r + CNT_W'(1);
        end
        // Read data of the slot issued in the previous cycle.
        if (cmp_vld_r && valid_r[cmp_idx_r]) begin
          if (op_fire_r) begin
            if (better) begin
              best_found_nxt = 1'b1;
              best_nxt       = rd_ent;
              best_idx_nxt   = cmp_idx_r;
            end
          end else if ((rd_ent.machine == cmd_r.machine) &&
                       (rd_ent.level == cmd_r.level)) begin
            valid_nxt[cmp_idx_r] = 1'b0;
          end
        end
        if ((cnt_r == CNT_END) && !cmp_vld_r) begin
          state_nxt = op_fire_r ? S_RESULT : S_IDLE;
        end
      end

      S_RESULT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          if (best_found_r) begin
            valid_nxt[best_idx_r] = 1'b0;
          end
          if (later_due) begin
            clock_now_nxt = best_r.due;
          end
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    res = '0;
    res.time_now = later_due ? best_r.due : clock_now_r;
    if (best_found_r) begin
      res.fired      = 1'b1;
      res.machine    = best_r.machine;
      res.level      = best_r.level;
      res.event_code = best_r.event_code;
      res.due        = best_r.due;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cmp_vld_r    <= 1'b0;
      valid_r      <= '0;
      clock_now_r  <= '0;
      order_next_r <= '0;
      best_found_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      valid_r      <= valid_nxt;
      clock_now_r  <= clock_now_nxt;
      order_next_r <= order_next_nxt;
      best_found_r <= best_found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_fire_r  <= op_fire_nxt;
    cmd_r      <= cmd_nxt;
    cnt_r      <= cnt_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
  end

  // A start never overwrites a slot that is still armed.
  a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !valid_r[ram_waddr])
    else $error("start wrote into an armed slot");

  // A delivered timer is disarmed right after its result leaves.
  a_fire_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready && best_found_r) |=> !valid_r[$past(best_idx_r)])
    else $error("fired slot still armed");

  // Simulated time only moves forward.
  a_clock_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (clock_now_r >= $past(clock_now_r)))
    else $error("clock moved backward");

  // The best candidate of a fire scan is always an armed slot.
  a_best_armed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESULT && best_found_r) |-> valid_r[best_idx_r])
    else $error("selected slot is not armed");

endmodule

// ----- hdl/earliest_deadline_timer_table_core.sv -----
// Start walks the valid bits to the first free slot; a full table takes the longest.
// Stop and fire scan every slot, limited by one slot-memory read per cycle; a fire then
// passes its result to the output register before the next word is accepted.
// One word is in work at a time; a new word is taken while a result waits in the output register.
// Reset clears the slot valid bits, the clock and the order counter at once; the slot
// memory itself is not cleared.
// Top level: input handshake, sequencer edtt_seq and the output register (uses edtt_pkg).
module earliest_deadline_timer_table_core
  import edtt_pkg::*;
#(
  parameter int NUM_TIMERS = EDTT_NUM_TIMERS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [3:0]  in_machine_id,
  input  logic [7:0]  in_nest_level,
  input  logic [15:0] in_event_code,
  input  logic [31:0] in_delay_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_fired,
  output logic [31:0] out_time_now,
  output logic [3:0]  out_machine,
  output logic [7:0]  out_level,
  output logic [15:0] out_event,
  output logic [31:0] out_due_time
);

  cmd_t cmd;
  res_t res;
  logic res_valid;
  logic res_ready;
  logic out_valid_r, out_valid_nxt;
  res_t out_r;

  assign cmd = '{func: in_func, machine: in_machine_id, level: in_nest_level,
                 event_code: in_event_code, delay: in_delay_ms};

  edtt_seq #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (in_valid),
    .cmd_ready (in_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_fired    = out_r.fired;
  assign out_time_now = out_r.time_now;
  assign out_machine  = out_r.machine;
  assign out_level    = out_r.level;
  assign out_event    = out_r.event_code;
  assign out_due_time = out_r.due;

  // A word that reports no expiry carries zero timer fields.
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_fired) |-> (out_machine == 4'd0 && out_level == 8'd0 &&
                                   out_event == 16'd0 && out_due_time == 32'd0))
    else $error("empty fire result has nonzero fields");

  // The output register is only loaded when it is free or being drained.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && out_valid_r && !out_ready) |=> $stable(out_r))
    else $error("pending result overwritten");

  // A completed fire always leaves a word in the output register.
  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready) |=> out_valid_r)
    else $error("result lost");

endmodule
